// ===== rtl/sndag_pkg.sv =====
package sndag_pkg;

    // Fixed field widths of the register map and the datapath.
    localparam int HW_DIMS    = 4;   // dimensions that have shape and stride fields
    localparam int SIZE_W     = 16;
    localparam int STRIDE_W   = 32;
    localparam int BASE_W     = 32;
    localparam int PROD_W     = STRIDE_W + SIZE_W;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int NDIM_W     = 3;
    localparam int ADDR_OUT_W = 32;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_N_DIMS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDES_LO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDES_HI = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE       = 3'd4;

    localparam logic [NDIM_W-1:0] N_DIMS_RESET = 3'd1;
    localparam logic [CFG_W-1:0]  SHAPE_RESET  = 64'h0001_0001_0001_0001;

    typedef logic [SIZE_W-1:0]   t_index;
    typedef logic [STRIDE_W-1:0] t_stride;
    typedef logic [PROD_W-1:0]   t_prod;

    // Raw contents of the register file.
    typedef struct packed {
        logic [NDIM_W-1:0] n_dims;
        logic [CFG_W-1:0]  shape;
        logic [CFG_W-1:0]  strides_lo;
        logic [CFG_W-1:0]  strides_hi;
        logic [BASE_W-1:0] base;
    } t_regs;

    // One accepted request word as seen by the index counter.
    typedef struct packed {
        logic fire;
        logic start;
    } t_step;

endpackage

// ===== rtl/sndag_req_if.sv =====
interface sndag_req_if;
    logic valid;
    logic ready;
    logic start_req;

    modport source (output valid, output start_req, input ready);
    modport sink   (input valid, input start_req, output ready);
endinterface

// ===== rtl/sndag_res_if.sv =====
interface sndag_res_if;
    import sndag_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ADDR_OUT_W-1:0] address;
    logic                  last;
    logic                  overflow;

    modport source (output valid, output address, output last, output overflow, input ready);
    modport sink   (input valid, input address, input last, input overflow, output ready);
endinterface

// ===== rtl/sndag_cfg_regs.sv =====
module sndag_cfg_regs #(
    parameter int MAX_DIMS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sndag_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sndag_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic [MAX_DIMS-1:0]            o_active,
    output sndag_pkg::t_index              o_size   [MAX_DIMS],
    output sndag_pkg::t_stride             o_stride [MAX_DIMS],
    output logic [sndag_pkg::BASE_W-1:0]    o_base
);
    import sndag_pkg::*;

    t_regs r_regs;
    logic [NDIM_W-1:0] n_eff;
    logic [2*CFG_W-1:0] strides_all;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.n_dims     <= N_DIMS_RESET;
            r_regs.shape      <= SHAPE_RESET;
            r_regs.strides_lo <= '0;
            r_regs.strides_hi <= '0;
            r_regs.base       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_N_DIMS:     r_regs.n_dims     <= i_cfg_wdata[NDIM_W-1:0];
                REG_SHAPE:      r_regs.shape      <= i_cfg_wdata;
                REG_STRIDES_LO: r_regs.strides_lo <= i_cfg_wdata;
                REG_STRIDES_HI: r_regs.strides_hi <= i_cfg_wdata;
                REG_BASE:       r_regs.base       <= i_cfg_wdata[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    // A dimension count of zero behaves as one; counts above MAX_DIMS
    // saturate because no dimension beyond MAX_DIMS exists.
    assign n_eff       = (r_regs.n_dims == '0) ? NDIM_W'(1) : r_regs.n_dims;
    assign strides_all = {r_regs.strides_hi, r_regs.strides_lo};
    assign o_base      = r_regs.base;

    for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
        assign o_active[k] = (4'(k) < {1'b0, n_eff});
        if (k < HW_DIMS) begin : g_hw
            logic [SIZE_W-1:0] raw_size;
            assign raw_size    = r_regs.shape[SIZE_W*k +: SIZE_W];
            assign o_size[k]   = (raw_size == '0) ? SIZE_W'(1) : raw_size;
            assign o_stride[k] = strides_all[STRIDE_W*k +: STRIDE_W];
        end else begin : g_pad
            assign o_size[k]   = SIZE_W'(1);
            assign o_stride[k] = '0;
        end
    end

endmodule

// ===== rtl/sndag_odometer.sv =====
module sndag_odometer #(
    parameter int MAX_DIMS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sndag_pkg::t_step    i_step,
    input  logic [MAX_DIMS-1:0] i_active,
    input  sndag_pkg::t_index   i_size [MAX_DIMS],
    output sndag_pkg::t_index   o_idx  [MAX_DIMS],
    output logic                o_last
);
    import sndag_pkg::*;

    t_index r_idx [MAX_DIMS];
    t_index n_idx [MAX_DIMS];

    // The snapshot is the index vector this word addresses; the carry ripples
    // from the innermost active dimension outward. Inactive dimensions pass
    // the carry through and hold zero.
    always_comb begin
        logic            carry;
        logic [SIZE_W:0] inc;
        logic            wrap;
        carry = 1'b1;
        for (int k = MAX_DIMS - 1; k >= 0; k--) begin
            o_idx[k] = (i_step.start || !i_active[k]) ? '0 : r_idx[k];
            inc      = {1'b0, o_idx[k]} + (SIZE_W+1)'(1);
            wrap     = (inc >= {1'b0, i_size[k]});
            if (i_active[k] && carry) begin
                n_idx[k] = wrap ? '0 : inc[SIZE_W-1:0];
                carry    = wrap;
            end else begin
                n_idx[k] = o_idx[k];
            end
        end
        o_last = carry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_DIMS; k++) r_idx[k] <= '0;
        end else if (i_step.fire) begin
            r_idx <= n_idx;
        end
    end

endmodule

// ===== rtl/sndag_addr_pipe.sv =====
module sndag_addr_pipe #(
    parameter int MAX_DIMS  = 4,
    parameter int ADDR_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  sndag_pkg::t_index                i_idx    [MAX_DIMS],
    input  logic                             i_last,
    input  sndag_pkg::t_stride               i_stride [MAX_DIMS],
    input  logic [sndag_pkg::BASE_W-1:0]      i_base,
    output logic                             o_valid,
    input  logic                             i_res_ready,
    output logic [sndag_pkg::ADDR_OUT_W-1:0] o_address,
    output logic                             o_last,
    output logic                             o_overflow
);
    import sndag_pkg::*;

    localparam int NPAIR  = (MAX_DIMS + 1) / 2;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + $clog2(MAX_DIMS + 1);
    localparam logic [SUM_W-1:0] ADDR_MASK = {{(SUM_W-ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};

    logic en1, en2, en3;
    logic r_v1, r_v2, r_v3;
    logic r_last1, r_last2, r_last3;
    t_prod r_prod [MAX_DIMS];
    t_prod prod_pad [2*NPAIR];
    logic [PAIR_W-1:0] r_pair [NPAIR];
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  masked;
    logic [ADDR_OUT_W-1:0] r_address;
    logic r_overflow;

    // Each stage moves when the stage after it is empty or moving.
    assign en3     = !r_v3 || i_res_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // Stage 1: one stride times index product per dimension.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int k = 0; k < MAX_DIMS; k++) begin
                r_prod[k] <= PROD_W'(i_stride[k]) * PROD_W'(i_idx[k]);
            end
            r_last1 <= i_last;
        end
    end

    always_comb begin
        for (int k = 0; k < 2*NPAIR; k++) begin
            prod_pad[k] = (k < MAX_DIMS) ? r_prod[k % MAX_DIMS] : '0;
        end
    end

    // Stage 2: products added in pairs.
    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int j = 0; j < NPAIR; j++) begin
                r_pair[j] <= PAIR_W'(prod_pad[2*j]) + PAIR_W'(prod_pad[2*j+1]);
            end
            r_last2 <= r_last1;
        end
    end

    // Stage 3: base plus pair sums, then range check against ADDR_BITS.
    always_comb begin
        sum = SUM_W'(i_base);
        for (int j = 0; j < NPAIR; j++) begin
            sum = sum + SUM_W'(r_pair[j]);
        end
        masked = sum & ADDR_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_address  <= masked[ADDR_OUT_W-1:0];
            r_overflow <= |sum[SUM_W-1:ADDR_BITS];
            r_last3    <= r_last2;
        end
    end

    assign o_valid    = r_v3;
    assign o_address  = r_address;
    assign o_last     = r_last3;
    assign o_overflow = r_overflow;

endmodule

// ===== rtl/strided_nd_address_generator_core.sv =====
// Strided N-dimensional address generator. Every accepted request word yields
// one result word: base_offset plus the sum of stride times index over the
// active dimensions, the last flag when that element closes the traversal,
// and an overflow flag when the full sum does not fit in ADDR_BITS. The index
// vector steps like an odometer with dimension 0 outermost; start_req clears
// it before the word is addressed. The block takes one word per clock cycle
// for as long as results are drained. Each accepted request has its result
// formed in registered steps: the per-dimension multipliers, the pairwise
// adders and the final adder with the range check. The index counter itself
// updates in the cycle the request is accepted, so back-to-back requests
// never wait on one another. The user writes registers through the plain
// write port only while the block holds no pending words; nothing enforces it.
module strided_nd_address_generator_core #(
    parameter int MAX_DIMS  = 4,
    parameter int ADDR_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sndag_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sndag_pkg::CFG_W-1:0]     i_cfg_wdata,
    sndag_req_if.sink                       i_req,
    sndag_res_if.source                     o_res
);
    import sndag_pkg::*;

    logic [MAX_DIMS-1:0] active;
    t_index              size   [MAX_DIMS];
    t_stride             stride [MAX_DIMS];
    t_index              idx    [MAX_DIMS];
    logic [BASE_W-1:0]   base;
    logic                last;
    logic                ready;
    t_step               step;

    // A request word is taken whenever the product stage can load.
    assign i_req.ready = ready;
    assign step.fire   = i_req.valid && ready;
    assign step.start  = i_req.start_req;

    sndag_cfg_regs #(
        .MAX_DIMS (MAX_DIMS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_active    (active),
        .o_size      (size),
        .o_stride    (stride),
        .o_base      (base)
    );

    // The counter hands out the index vector of the current word and the
    // last flag, and advances on the same edge that accepts the word.
    sndag_odometer #(
        .MAX_DIMS (MAX_DIMS)
    ) u_odo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_active (active),
        .i_size   (size),
        .o_idx    (idx),
        .o_last   (last)
    );

    // Three-stage address datapath; its final stage is the output register.
    sndag_addr_pipe #(
        .MAX_DIMS  (MAX_DIMS),
        .ADDR_BITS (ADDR_BITS)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (step.fire),
        .o_ready     (ready),
        .i_idx       (idx),
        .i_last      (last),
        .i_stride    (stride),
        .i_base      (base),
        .o_valid     (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_address   (o_res.address),
        .o_last      (o_res.last),
        .o_overflow  (o_res.overflow)
    );

endmodule

// ===== rtl/sndag_checker.sv =====
module sndag_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [31:0] i_res_address,
    input logic        i_res_last,
    input logic        i_res_overflow
);
    // Words accepted but not yet delivered.
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    assign n_cnt = r_cnt + 3'(i_req_valid && i_req_ready) - 3'(i_res_valid && i_res_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_address)
            && $stable(i_res_last) && $stable(i_res_overflow))
        else $error("stalled result word changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> r_cnt != 3'd0)
        else $error("result word without a pending request");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd3)
        else $error("more words in flight than pipeline stages");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_req_ready)
        else $error("request stalled while output register is empty");

endmodule

bind strided_nd_address_generator_core sndag_checker u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_address  (o_res.address),
    .i_res_last     (o_res.last),
    .i_res_overflow (o_res.overflow)
);
